// ----- rtl/core/ecfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ecfr_pkg
// shared types, constants and the crc step for the escaped crc frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package ecfr_pkg;

  localparam int unsigned TOK_DEPTH = 4;
  localparam int unsigned TOK_PTR_W = $clog2(TOK_DEPTH);
  localparam int unsigned TOK_CNT_W = TOK_PTR_W + 1;

  localparam logic [7:0]  START_RESET  = 8'hFD;
  localparam logic [7:0]  ESCAPE_RESET = 8'hFC;
  localparam logic [15:0] POLY_RESET   = 16'h8005;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [7:0]  ESC_BIT      = 8'h80;

  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_GOOD  = 3'd1,
    KIND_BAD   = 3'd2,
    KIND_DROP  = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CFG_START  = 2'd0,
    CFG_ESCAPE = 2'd1,
    CFG_POLY   = 2'd2
  } cfg_index_t;

  // classified, de-escaped byte headed for the frame parser
  typedef struct packed {
    logic       is_start;
    logic [7:0] value;
  } token_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] length;
  } result_t;

  // msb-first crc-16 over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  v,
                                           input logic [15:0] poly);
    logic [15:0] crc;
    logic        top;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      top = crc[15] ^ v[7 - k];
      crc = {crc[14:0], 1'b0};
      if (top) begin
        crc = crc ^ poly;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ecfr_front.sv -----
// ----------------------------------------------------------------------------
// ecfr_front
// classifies raw bytes: start bytes, escapes and de-escaped data bytes
// ----------------------------------------------------------------------------
`default_nettype none

module ecfr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [7:0]      start_char,
  input  wire logic [7:0]      escape_char,
  output      logic            tok_wr,
  output      ecfr_pkg::token_t tok
);
  import ecfr_pkg::*;

  logic esc_pending;
  logic esc_pending_next;
  logic is_start;
  logic is_esc;

  assign is_start = (rx_byte == start_char);
  assign is_esc   = !is_start && (rx_byte == escape_char);

  // escape bytes are swallowed here, the following byte carries bit 7
  assign tok_wr       = accept && !is_esc;
  assign tok.is_start = is_start;
  assign tok.value    = (esc_pending && !is_start) ? (rx_byte | ESC_BIT) : rx_byte;

  always_comb begin
    esc_pending_next = esc_pending;
    if (accept) begin
      esc_pending_next = is_esc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_pending <= 1'b0;
    end else begin
      esc_pending <= esc_pending_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ecfr_tok_fifo.sv -----
// ----------------------------------------------------------------------------
// ecfr_tok_fifo
// short token queue between the classifier and the frame parser
// ----------------------------------------------------------------------------
`default_nettype none

module ecfr_tok_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire ecfr_pkg::token_t wr_data,
  input  wire logic             rd_en,
  output      ecfr_pkg::token_t rd_data,
  output      logic             empty,
  output      logic             full
);
  import ecfr_pkg::*;

  token_t               mem [TOK_DEPTH];
  logic [TOK_PTR_W-1:0] wr_ptr;
  logic [TOK_PTR_W-1:0] rd_ptr;
  logic [TOK_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign empty   = (count == TOK_CNT_W'(0));
  assign full    = (count == TOK_CNT_W'(TOK_DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + TOK_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + TOK_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + TOK_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - TOK_CNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= TOK_CNT_W'(TOK_DEPTH))
    else $error("token queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[TOK_PTR_W-1:0])
    else $error("token queue pointers disagree with count");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !rd_en) |=> full)
    else $error("token queue lost an entry while full");

endmodule

`default_nettype wire

// ----- rtl/core/ecfr_back.sv -----
// ----------------------------------------------------------------------------
// ecfr_back
// frame parser: header length, running crc, frame end report, result buffer
// ----------------------------------------------------------------------------
`default_nettype none

module ecfr_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [15:0]       crc_poly,
  input  wire logic              tok_valid,
  input  wire ecfr_pkg::token_t  tok,
  output      logic              tok_rd,
  input  wire logic              res_pop,
  output      logic              res_empty,
  output      ecfr_pkg::result_t res
);
  import ecfr_pkg::*;

  // parser state
  logic        in_frame,  in_frame_next;
  logic [16:0] pos,       pos_next;
  logic [15:0] exp_len,   exp_len_next;
  logic [15:0] crc,       crc_next;
  logic [7:0]  crc_hi,    crc_hi_next;

  // two-entry result buffer
  result_t     ent [2];
  logic        rd_ptr;
  logic [1:0]  res_cnt;
  logic        wr_idx;
  logic        do_pop;

  logic        emit;
  result_t     emit_res;
  logic [16:0] len_plus2;
  logic [15:0] crc_upd;

  assign res_empty = (res_cnt == 2'd0);
  assign do_pop    = res_pop && !res_empty;
  assign res       = ent[rd_ptr];
  assign tok_rd    = tok_valid && ((res_cnt != 2'd2) || do_pop);
  assign wr_idx    = rd_ptr ^ (res_cnt == 2'd1);
  assign len_plus2 = {1'b0, exp_len} + 17'd2;
  assign crc_upd   = crc_byte(crc, tok.value, crc_poly);

  always_comb begin
    in_frame_next = in_frame;
    pos_next      = pos;
    exp_len_next  = exp_len;
    crc_next      = crc;
    crc_hi_next   = crc_hi;
    emit          = 1'b0;
    emit_res      = '{kind: KIND_BYTE, data: 8'd0, length: 16'd0};
    if (tok_rd) begin
      if (tok.is_start) begin
        if (in_frame) begin
          emit     = 1'b1;
          emit_res = '{kind: KIND_DROP, data: 8'd0, length: exp_len};
        end
        in_frame_next = 1'b1;
        pos_next      = '0;
        exp_len_next  = '0;
        crc_next      = CRC_INIT;
        crc_hi_next   = '0;
      end else if (in_frame) begin
        if (pos == 17'd0) begin
          exp_len_next = {tok.value, 8'd0};
          crc_next     = crc_upd;
          pos_next     = 17'd1;
        end else if (pos == 17'd1) begin
          exp_len_next = {exp_len[15:8], tok.value};
          crc_next     = crc_upd;
          pos_next     = 17'd2;
        end else if (pos < len_plus2) begin
          crc_next = crc_upd;
          pos_next = pos + 17'd1;
          emit     = 1'b1;
          emit_res = '{kind: KIND_BYTE, data: tok.value, length: 16'd0};
        end else if (pos == len_plus2) begin
          crc_hi_next = tok.value;
          pos_next    = pos + 17'd1;
        end else begin
          // second crc byte closes the frame
          emit = 1'b1;
          emit_res.length = exp_len;
          if (exp_len == 16'd0) begin
            emit_res.kind = KIND_EMPTY;
          end else if (crc_hi == crc[15:8] && tok.value == crc[7:0]) begin
            emit_res.kind = KIND_GOOD;
          end else begin
            emit_res.kind = KIND_BAD;
          end
          in_frame_next = 1'b0;
          pos_next      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      pos      <= '0;
      exp_len  <= '0;
      crc      <= CRC_INIT;
      crc_hi   <= '0;
    end else begin
      in_frame <= in_frame_next;
      pos      <= pos_next;
      exp_len  <= exp_len_next;
      crc      <= crc_next;
      crc_hi   <= crc_hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ent[wr_idx] <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (emit && !do_pop) begin
        res_cnt <= res_cnt + 2'd1;
      end else if (do_pop && !emit) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= 2'd2)
    else $error("result buffer overflow");

  a_hunt_pos: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (pos == 17'd0))
    else $error("frame position nonzero while hunting");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (pos <= ({1'b0, exp_len} + 17'd3)))
    else $error("frame position beyond crc trailer");

  a_end_hunt: assert property (@(posedge clk) disable iff (rst)
    (emit && (emit_res.kind == KIND_GOOD || emit_res.kind == KIND_BAD ||
              emit_res.kind == KIND_EMPTY)) |=> !in_frame)
    else $error("parser still in frame after frame end");

endmodule

`default_nettype wire

// ----- rtl/core/escaped_crc_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// escaped_crc_frame_receiver_core
// byte-stuffed frame receiver with crc-16 check, one raw byte per beat
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  -------   ----------------   ----------------------------------
//  input     push / full        rx_byte
//  result    empty / pop        kind, data, frame_length
//  config    wr_en              wr_index, wr_data (start, escape, poly)
//
//  one input beat per cycle sustained while full is low; a byte taken sits in
//  the token queue, is parsed from there into the result buffer, and any
//  result it yields is on the result ports from then on, ready to be popped
//  the unrolled 8-bit crc step in the parser sets the cycle time
//  rst is synchronous: hunting for a start byte, config back to 0xfd/0xfc/0x8005
//  a stalled result side fills the two-entry result buffer, then the
//  four-entry token queue, and only then raises full
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_crc_frame_receiver_core (
  input  wire logic            clk,
  input  wire logic            rst,
  // input beats
  input  wire logic            push,
  output      logic            full,
  input  wire logic [7:0]      rx_byte,
  // result beats
  output      logic            empty,
  input  wire logic            pop,
  output      logic [2:0]      kind,
  output      logic [7:0]      data,
  output      logic [15:0]     frame_length,
  // configuration writes
  input  wire logic            wr_en,
  input  wire logic [1:0]      wr_index,
  input  wire logic [15:0]     wr_data
);
  import ecfr_pkg::*;

  // configuration registers
  logic [7:0]  start_char;
  logic [7:0]  escape_char;
  logic [15:0] crc_poly;

  // front to queue
  logic    accept;
  logic    tok_wr;
  token_t  tok_in;

  // queue to parser
  token_t  tok_out;
  logic    tok_empty;
  logic    tok_rd;

  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char  <= START_RESET;
      escape_char <= ESCAPE_RESET;
      crc_poly    <= POLY_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_START:  start_char  <= wr_data[7:0];
        CFG_ESCAPE: escape_char <= wr_data[7:0];
        CFG_POLY:   crc_poly    <= wr_data;
        default: ; // unused index, write dropped
      endcase
    end
  end

  assign accept = push && !full;

  // classify and de-escape incoming bytes
  ecfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .start_char  (start_char),
    .escape_char (escape_char),
    .tok_wr      (tok_wr),
    .tok         (tok_in)
  );

  // decouples the classifier from the parser
  ecfr_tok_fifo u_tok_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tok_wr),
    .wr_data (tok_in),
    .rd_en   (tok_rd),
    .rd_data (tok_out),
    .empty   (tok_empty),
    .full    (full)
  );

  // frame parser, crc and result buffer
  ecfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .crc_poly  (crc_poly),
    .tok_valid (!tok_empty),
    .tok       (tok_out),
    .tok_rd    (tok_rd),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign kind         = res.kind;
  assign data         = res.data;
  assign frame_length = res.length;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the escaped crc frame receiver core
// ----------------------------------------------------------------------------
// a byte-level deframer model predicts every random-traffic beat. a short
// table of hand-built frames (empty, good, bad crc, dropped, escapes) runs
// first, then random frames under several start/escape/polynomial settings.
// both sides of the queue handshake idle at random, the result side holds
// off once long enough to back up the input, and the sender drains fully
// before each set of register writes
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ecfr_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE       = 12;     // token queue + result buffer + margin
  localparam int PHASE_ITEMS  = 150;
  localparam int PHASE_COUNT  = 6;
  localparam int IDLE_PCT     = 16;
  localparam int HOLD_AT_BEAT = 80;
  localparam int HOLD_CYCLES  = 400;

  localparam result_t NO_RESULT = '0;

  // how a table row picks its byte
  typedef enum logic [1:0] {
    ROW_RAW     = 2'd0,   // byte as written
    ROW_CRC_HI  = 2'd1,   // high byte of the running crc
    ROW_CRC_LO  = 2'd2,   // low byte of the running crc
    ROW_CRC_BAD = 2'd3    // inverted low byte, forces a mismatch
  } row_mode_t;

  typedef struct packed {
    row_mode_t   mode;
    logic [7:0]  value;
    logic        typed;    // expected beat given below instead of predicted
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] length;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and dut ports, inputs known from time zero
  // ---------------------------------------------------------------------------
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        push     = 1'b0;
  logic [7:0]  rx_byte  = 8'h00;
  logic        pop      = 1'b0;
  logic        wr_en    = 1'b0;
  cfg_index_t  wr_index = CFG_START;
  logic [15:0] wr_data  = 16'h0000;
  logic        full;
  logic        empty;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [15:0] frame_length;

  always #6 clk = ~clk;

  escaped_crc_frame_receiver_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .data         (data),
    .frame_length (frame_length),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  // ---------------------------------------------------------------------------
  // deframer model: register copy and frame state
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_start  = START_RESET;
  logic [7:0]  cfg_escape = ESCAPE_RESET;
  logic [15:0] cfg_poly   = POLY_RESET;

  bit          frm_open  = 1'b0;
  bit          esc_armed = 1'b0;
  logic [16:0] frm_pos   = '0;     // de-escaped bytes since the start byte
  logic [15:0] hdr_len   = '0;
  logic [15:0] crc_acc   = CRC_INIT;
  logic [7:0]  crc_hi_rx = '0;

  result_t     due_results_q[$];   // predicted beats, oldest first
  int          items_sent = 0;
  int          beats_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  // msb-first crc, byte folded into the top then shifted out
  function automatic logic [15:0] crc16_step8(input logic [15:0] crc,
                                              input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      acc = acc[15] ? ({acc[14:0], 1'b0} ^ cfg_poly) : {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic void open_frame_model();
    frm_open  = 1'b1;
    esc_armed = 1'b0;
    frm_pos   = '0;
    hdr_len   = '0;
    crc_acc   = CRC_INIT;
    crc_hi_rx = '0;
  endfunction

  // one raw byte in, at most one beat out
  function automatic bit deframe_byte(input logic [7:0] raw, output result_t res);
    logic [7:0]  c;
    logic [16:0] crc_at;
    c   = raw;
    res = NO_RESULT;
    // start byte wins over escape, even when both chars are equal
    if (c == cfg_start) begin
      if (frm_open) begin
        res.kind   = KIND_DROP;
        res.length = hdr_len;
        open_frame_model();
        return 1'b1;
      end
      open_frame_model();
      return 1'b0;
    end
    if (!frm_open) return 1'b0;
    if (c == cfg_escape) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    if (esc_armed) begin
      c = c | ESC_BIT;
      esc_armed = 1'b0;
    end
    crc_at = {1'b0, hdr_len} + 17'd2;
    if (frm_pos == 17'd0) begin
      hdr_len = {c, 8'h00};
      crc_acc = crc16_step8(crc_acc, c);
      frm_pos = 17'd1;
      return 1'b0;
    end
    if (frm_pos == 17'd1) begin
      hdr_len[7:0] = c;
      crc_acc = crc16_step8(crc_acc, c);
      frm_pos = 17'd2;
      return 1'b0;
    end
    if (frm_pos < crc_at) begin
      crc_acc  = crc16_step8(crc_acc, c);
      frm_pos  = frm_pos + 17'd1;
      res.kind = KIND_BYTE;
      res.data = c;
      return 1'b1;
    end
    if (frm_pos == crc_at) begin
      crc_hi_rx = c;
      frm_pos   = frm_pos + 17'd1;
      return 1'b0;
    end
    // second crc byte closes the frame
    if (hdr_len == 16'd0)                res.kind = KIND_EMPTY;
    else if ({crc_hi_rx, c} == crc_acc)  res.kind = KIND_GOOD;
    else                                 res.kind = KIND_BAD;
    res.length = hdr_len;
    frm_open   = 1'b0;
    esc_armed  = 1'b0;
    frm_pos    = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // sender: one input beat, random gap in front, no gaps mid-run for a while
  // ---------------------------------------------------------------------------
  task automatic send_raw(input logic [7:0] b, input bit use_typed,
                          input result_t typed_res);
    result_t r;
    bit      has;
    if (!(items_sent >= 350 && items_sent < 550) &&
        $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    // full sampled before the edge updates it
    do @(posedge clk); while (full);
    has = deframe_byte(b, r);
    if (use_typed) begin
      r   = typed_res;
      has = 1'b1;
    end
    if (has) due_results_q.push_back(r);
    items_sent++;
  endtask

  // frame byte on the line: escapes what collides, sometimes what needn't
  task automatic send_coded(input logic [7:0] b, input bit use_typed,
                            input result_t typed_res);
    logic [7:0] v;
    bit         clash;
    v = b;
    clash = (v == cfg_start) || (v == cfg_escape);
    if (cfg_start == cfg_escape) begin
      // no escape possible here, the colliding value goes out changed
      if (clash) v = v & 8'h7f;
    end else if (clash || (v[7] && $urandom_range(9) == 0)) begin
      send_raw(cfg_escape, 1'b0, NO_RESULT);
      if ($urandom_range(7) == 0) send_raw(cfg_escape, 1'b0, NO_RESULT);
      if (clash || $urandom_range(1) == 1) v = v & 8'h7f;
    end
    send_raw(v, use_typed, typed_res);
  endtask

  // mostly well-formed frames, some cut short, some line noise
  task automatic send_random_traffic();
    int          pick;
    int          nbytes;
    logic [15:0] flen;
    logic [15:0] crc_tx;
    pick = $urandom_range(99);
    if (pick < 72) begin
      nbytes = $urandom_range(99);
      if (nbytes < 10)      flen = 16'd0;
      else if (nbytes < 85) flen = 16'($urandom_range(8, 1));
      else if (nbytes < 97) flen = 16'($urandom_range(40, 9));
      else                  flen = 16'($urandom_range(300, 100));
      send_raw(cfg_start, 1'b0, NO_RESULT);
      send_coded(flen[15:8], 1'b0, NO_RESULT);
      send_coded(flen[7:0], 1'b0, NO_RESULT);
      for (int k = 0; k < int'(flen); k++) begin
        send_coded(8'($urandom_range(255)), 1'b0, NO_RESULT);
      end
      crc_tx = crc_acc;
      if ($urandom_range(99) < 15) crc_tx = crc_tx ^ (16'h0001 << $urandom_range(15));
      send_coded(crc_tx[15:8], 1'b0, NO_RESULT);
      send_coded(crc_tx[7:0], 1'b0, NO_RESULT);
    end else if (pick < 84) begin
      // frame cut short, next start byte drops it
      send_raw(cfg_start, 1'b0, NO_RESULT);
      nbytes = $urandom_range(4);
      for (int k = 0; k < nbytes; k++) begin
        send_coded(8'($urandom_range(255)), 1'b0, NO_RESULT);
      end
    end else if (pick < 93) begin
      nbytes = $urandom_range(6, 1);
      for (int k = 0; k < nbytes; k++) begin
        send_raw(8'($urandom_range(255)), 1'b0, NO_RESULT);
      end
    end else begin
      // junk between frames, escape char among it
      send_raw(8'($urandom_range(127)), 1'b0, NO_RESULT);
      send_raw(cfg_escape, 1'b0, NO_RESULT);
    end
  endtask

  // stop sending, let every predicted beat arrive, then let the pipe go quiet
  task automatic drain_results();
    push <= 1'b0;
    while (due_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // all three registers, back to back, only while idle
  task automatic write_config(input logic [7:0] s, input logic [7:0] e,
                              input logic [15:0] p);
    wr_en    <= 1'b1;
    wr_index <= CFG_START;
    wr_data  <= {8'h00, s};
    @(posedge clk);
    wr_index <= CFG_ESCAPE;
    wr_data  <= {8'h00, e};
    @(posedge clk);
    wr_index <= CFG_POLY;
    wr_data  <= p;
    @(posedge clk);
    wr_en      <= 1'b0;
    cfg_start  = s;
    cfg_escape = e;
    cfg_poly   = p;
  endtask

  // ---------------------------------------------------------------------------
  // result side: check each popped beat, random pop gaps, one long hold-off
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      // pop/empty read as they stood before this edge
      if (pop && !empty) begin
        if (due_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind %0d data %02h len %0d",
                                    kind, data, frame_length));
        end else begin
          want = due_results_q.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("beat %0d kind %0d, want %0d",
                                      beats_seen, kind, want.kind));
          if (data !== want.data)
            report_mismatch($sformatf("beat %0d data %02h, want %02h",
                                      beats_seen, data, want.data));
          if (frame_length !== want.length)
            report_mismatch($sformatf("beat %0d frame_length %0d, want %0d",
                                      beats_seen, frame_length, want.length));
        end
        beats_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (beats_seen == HOLD_AT_BEAT && !hold_done) begin
        // long stall: result buffer, then token queue fill, then full rises
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (beats_seen >= 250 && beats_seen < 450) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed frames under reset config (start fd, escape fc, poly 8005)
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [28] = '{
    // junk while hunting, escape char included
    '{ROW_RAW,     8'h00, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'hFC, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    // zero length frame, crc bytes taken but not checked
    '{ROW_RAW,     8'hFD, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h00, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h00, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h12, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h34, 1'b1, KIND_EMPTY, 8'h00, 16'h0000},
    // two byte frame, escape after escape, good crc
    '{ROW_RAW,     8'hFD, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h00, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h02, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'hFC, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'hFC, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h7F, 1'b1, KIND_BYTE,  8'hFF, 16'h0000},
    '{ROW_RAW,     8'h00, 1'b1, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_CRC_HI,  8'h00, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_CRC_LO,  8'h00, 1'b1, KIND_GOOD,  8'h00, 16'h0002},
    // start byte after escape: drop before the header, pending escape gone
    '{ROW_RAW,     8'hFD, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'hFC, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'hFD, 1'b1, KIND_DROP,  8'h00, 16'h0000},
    // max length header, one byte, then dropped
    '{ROW_RAW,     8'hFF, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'hFF, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h80, 1'b1, KIND_BYTE,  8'h80, 16'h0000},
    '{ROW_RAW,     8'hFD, 1'b1, KIND_DROP,  8'h00, 16'hFFFF},
    // one byte frame with a broken crc
    '{ROW_RAW,     8'h00, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h01, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_RAW,     8'h55, 1'b1, KIND_BYTE,  8'h55, 16'h0000},
    '{ROW_CRC_HI,  8'h00, 1'b0, KIND_BYTE,  8'h00, 16'h0000},
    '{ROW_CRC_BAD, 8'h00, 1'b1, KIND_BAD,   8'h00, 16'h0001}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    result_t   typed_res;
    int        goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      typed_res.kind   = row.kind;
      typed_res.data   = row.data;
      typed_res.length = row.length;
      case (row.mode)
        ROW_RAW:     send_raw(row.value, row.typed, typed_res);
        ROW_CRC_HI:  send_coded(crc_acc[15:8], row.typed, typed_res);
        ROW_CRC_LO:  send_coded(crc_acc[7:0], row.typed, typed_res);
        ROW_CRC_BAD: send_coded(~crc_acc[7:0], row.typed, typed_res);
        default:     send_raw(row.value, row.typed, typed_res);
      endcase
    end

    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) send_random_traffic();

    // further settings: low/high extremes, start equal to escape, random, then reset chars with poly 1021
    for (int ph = 1; ph < PHASE_COUNT; ph++) begin
      drain_results();
      case (ph)
        1:       write_config(8'h80, 8'hFF, 16'h0000);
        2:       write_config(8'hFF, 8'h80, 16'hFFFF);
        3:       write_config(8'hC3, 8'hC3, 16'($urandom));
        4:       write_config(8'($urandom_range(255, 128)),
                              8'($urandom_range(255, 128)), 16'($urandom));
        default: write_config(START_RESET, ESCAPE_RESET, 16'h1021);
      endcase
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_random_traffic();
    end

    // any stray beat in the settle window is flagged by the checker
    drain_results();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ecfr_pkg.sv
rtl/core/ecfr_front.sv
rtl/core/ecfr_tok_fifo.sv
rtl/core/ecfr_back.sv
rtl/core/escaped_crc_frame_receiver_core.sv
tb/tb_top.sv
